/* rtl/uatc_pkg.sv */
package uatc_pkg;

   localparam int UID_W    = 32;
   localparam int FUNC_W   = 3;
   localparam int ACCESS_W = 2;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // operation codes carried in the func field
   typedef enum logic [FUNC_W-1:0] {
      FUNC_CHECK   = 3'd0,
      FUNC_ALLOW   = 3'd1,
      FUNC_DENY    = 3'd2,
      FUNC_SET_RO  = 3'd3,
      FUNC_SET_RW  = 3'd4,
      FUNC_REMOVE  = 3'd5
   } func_type;

   typedef enum logic [ACCESS_W-1:0] {
      ACC_DENIED = 2'd0,
      ACC_RO     = 2'd1,
      ACC_RW     = 2'd2
   } access_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_OWNER   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACL_ENABLED       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWNER_UID         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIVATE_MODE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKED            = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PASSCODE_REQUIRED = 3'd4;

   // table update commands; the insert kinds find or create the entry
   typedef enum logic [2:0] {
      UPD_NONE       = 3'd0,
      UPD_CLR_DENIED = 3'd1,
      UPD_SET_DENIED = 3'd2,
      UPD_SET_RO     = 3'd3,
      UPD_CLR_RO     = 3'd4,
      UPD_REMOVE     = 3'd5
   } upd_op_type;

   typedef struct packed {
      logic       valid;
      upd_op_type op;
   } update_type;

   typedef struct packed {
      logic hit;
      logic denied;
      logic readonly;
      logic full;
   } lookup_type;

endpackage

/* rtl/uatc_req_if.sv */
interface uatc_req_if;
   logic                          valid;
   logic                          ready;
   logic [uatc_pkg::FUNC_W-1:0]   func;
   logic [uatc_pkg::UID_W-1:0]    uid;

   modport source (output valid, func, uid, input ready);
   modport sink   (input valid, func, uid, output ready);
endinterface

/* rtl/uatc_rsp_if.sv */
interface uatc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [uatc_pkg::ACCESS_W-1:0]   access;
   logic                            needs_passcode;
   logic [uatc_pkg::STATUS_W-1:0]   status;

   modport source (output valid, access, needs_passcode, status, input ready);
   modport sink   (input valid, access, needs_passcode, status, output ready);
endinterface

/* rtl/uatc_table.sv */
module uatc_table #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [uatc_pkg::UID_W-1:0]   key,
   input  uatc_pkg::update_type         upd,
   output uatc_pkg::lookup_type         look
);

   logic [TABLE_ENTRIES-1:0]      valid_ff;
   logic [TABLE_ENTRIES-1:0]      valid_in;
   logic [uatc_pkg::UID_W-1:0]    uid_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]      denied_ff;
   logic [TABLE_ENTRIES-1:0]      denied_in;
   logic [TABLE_ENTRIES-1:0]      ro_ff;
   logic [TABLE_ENTRIES-1:0]      ro_in;
   logic [TABLE_ENTRIES-1:0]      hit_vec;
   logic [TABLE_ENTRIES-1:0]      free_vec;
   logic [TABLE_ENTRIES-1:0]      free_first;
   logic [TABLE_ENTRIES-1:0]      tgt_vec;
   logic [TABLE_ENTRIES-1:0]      new_vec;
   logic                          is_insert;

   // parallel match, one comparator per entry
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (uid_ff[i] == key);
      end
   end

   // lowest free slot: isolate lowest set bit
   assign free_vec   = ~valid_ff;
   assign free_first = free_vec & (~free_vec + {{(TABLE_ENTRIES-1){1'b0}}, 1'b1});

   assign look.hit      = |hit_vec;
   assign look.denied   = |(hit_vec & denied_ff);
   assign look.readonly = |(hit_vec & ro_ff);
   assign look.full     = &valid_ff;

   assign is_insert = (upd.op == uatc_pkg::UPD_CLR_DENIED) ||
                      (upd.op == uatc_pkg::UPD_SET_DENIED) ||
                      (upd.op == uatc_pkg::UPD_SET_RO);

   assign tgt_vec = (is_insert && !look.hit) ? free_first : hit_vec;
   assign new_vec = (is_insert && !look.hit) ? free_first : '0;

   always_comb begin
      valid_in  = valid_ff;
      denied_in = denied_ff;
      ro_in     = ro_ff;
      if (upd.valid) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (new_vec[i]) begin
               valid_in[i]  = 1'b1;
               denied_in[i] = 1'b0;
               ro_in[i]     = 1'b0;
            end
            if (tgt_vec[i]) begin
               case (upd.op)
                  uatc_pkg::UPD_CLR_DENIED: denied_in[i] = 1'b0;
                  uatc_pkg::UPD_SET_DENIED: denied_in[i] = 1'b1;
                  uatc_pkg::UPD_SET_RO:     ro_in[i]     = 1'b1;
                  uatc_pkg::UPD_CLR_RO:     ro_in[i]     = 1'b0;
                  uatc_pkg::UPD_REMOVE:     valid_in[i]  = 1'b0;
                  default: ;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      denied_ff <= denied_in;
      ro_ff     <= ro_in;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (upd.valid && new_vec[i]) begin
            uid_ff[i] <= key;
         end
      end
   end

   // a uid is never held twice, so at most one entry matches
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one entry matches the key");

   a_full_no_insert: assert property (@(posedge clock) disable iff (reset)
      upd.valid && is_insert && !look.hit && look.full |=> $stable(valid_ff))
      else $error("insert into a full table changed the valid bits");

endmodule

/* rtl/user_access_table_check.sv */
// User access table check.
//
// req_ch carries one item per handshake: an operation code (func) and a user
// id. rsp_ch returns exactly one item per request item, in order: access,
// needs_passcode and status. Both channels use valid/ready; an item moves at
// a rising edge with valid and ready high.
// The csr_ port writes the five configuration registers (enable, owner uid,
// private, locked, passcode required); write only while the block is idle.
//
// Throughput: one item per cycle while the receiver does not stall. An accepted
// item sits in the input register, where a parallel match over all table
// entries finds its entry and the lowest free slot; the table update and the
// result register are loaded at the same edge, so the next item sees the new
// table. The item's result then goes to rsp_ch from the result register.
// If the receiver stalls, the result register holds and the input register
// fills; req_ch.ready then drops until the result is taken.
// Reset (synchronous, active high) clears all table valid bits, the configuration
// and the valid bits of both pipeline registers; no clearing pass is needed.
module user_access_table_check #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   uatc_req_if.sink                           req_ch,
   uatc_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [uatc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [uatc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // configuration
   logic                          acl_enabled_ff;
   logic [uatc_pkg::UID_W-1:0]    owner_uid_ff;
   logic                          private_mode_ff;
   logic                          locked_ff;
   logic                          passcode_required_ff;

   // input register
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [uatc_pkg::FUNC_W-1:0]   s1_func_ff;
   logic [uatc_pkg::UID_W-1:0]    s1_uid_ff;
   logic                          s1_advance;
   logic                          req_take;

   // result register
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   uatc_pkg::access_type          rsp_access_ff;
   uatc_pkg::access_type          rsp_access_in;
   logic                          rsp_needs_ff;
   logic                          rsp_needs_in;
   uatc_pkg::status_type          rsp_status_ff;
   uatc_pkg::status_type          rsp_status_in;

   uatc_pkg::lookup_type          look;
   uatc_pkg::update_type          upd;
   uatc_pkg::upd_op_type          upd_op;
   logic                          is_owner;
   logic                          is_root;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         acl_enabled_ff       <= 1'b0;
         owner_uid_ff         <= '0;
         private_mode_ff      <= 1'b0;
         locked_ff            <= 1'b0;
         passcode_required_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            uatc_pkg::CSR_ACL_ENABLED:       acl_enabled_ff       <= csr_wdata[0];
            uatc_pkg::CSR_OWNER_UID:         owner_uid_ff         <= csr_wdata;
            uatc_pkg::CSR_PRIVATE_MODE:      private_mode_ff      <= csr_wdata[0];
            uatc_pkg::CSR_LOCKED:            locked_ff            <= csr_wdata[0];
            uatc_pkg::CSR_PASSCODE_REQUIRED: passcode_required_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- handshake
   assign s1_advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_take ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff <= req_ch.func;
         s1_uid_ff  <= req_ch.uid;
      end
   end

   // -------------------------------------------------------------- table
   uatc_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .key   (s1_uid_ff),
      .upd   (upd),
      .look  (look)
   );

   assign is_owner = (s1_uid_ff == owner_uid_ff);
   assign is_root  = (s1_uid_ff == '0);

   // decision logic: result fields and the table command for the held item
   always_comb begin
      rsp_access_in = uatc_pkg::ACC_DENIED;
      rsp_needs_in  = 1'b0;
      rsp_status_in = uatc_pkg::ST_DONE;
      upd_op        = uatc_pkg::UPD_NONE;
      if (s1_func_ff == uatc_pkg::FUNC_CHECK) begin
         if (!acl_enabled_ff) begin
            rsp_access_in = uatc_pkg::ACC_RW;
         end else begin
            // locked beats everything; owner and root beat private and entries
            if (locked_ff) begin
               rsp_access_in = uatc_pkg::ACC_DENIED;
            end else if (is_owner || is_root) begin
               rsp_access_in = uatc_pkg::ACC_RW;
            end else if (private_mode_ff) begin
               rsp_access_in = uatc_pkg::ACC_DENIED;
            end else if (look.hit && look.denied) begin
               rsp_access_in = uatc_pkg::ACC_DENIED;
            end else if (look.hit && look.readonly) begin
               rsp_access_in = uatc_pkg::ACC_RO;
            end else begin
               rsp_access_in = uatc_pkg::ACC_RW;
            end
            rsp_needs_in = passcode_required_ff && !is_owner && !is_root;
         end
      end else if (acl_enabled_ff) begin
         case (s1_func_ff)
            uatc_pkg::FUNC_ALLOW: begin
               if (!look.hit && look.full) rsp_status_in = uatc_pkg::ST_FULL;
               else                        upd_op        = uatc_pkg::UPD_CLR_DENIED;
            end
            uatc_pkg::FUNC_DENY: begin
               if (is_owner)                    rsp_status_in = uatc_pkg::ST_OWNER;
               else if (!look.hit && look.full) rsp_status_in = uatc_pkg::ST_FULL;
               else                             upd_op        = uatc_pkg::UPD_SET_DENIED;
            end
            uatc_pkg::FUNC_SET_RO: begin
               if (!look.hit && look.full) rsp_status_in = uatc_pkg::ST_FULL;
               else                        upd_op        = uatc_pkg::UPD_SET_RO;
            end
            uatc_pkg::FUNC_SET_RW: begin
               if (!look.hit) rsp_status_in = uatc_pkg::ST_MISSING;
               else           upd_op        = uatc_pkg::UPD_CLR_RO;
            end
            uatc_pkg::FUNC_REMOVE: begin
               if (is_owner)       rsp_status_in = uatc_pkg::ST_OWNER;
               else if (!look.hit) rsp_status_in = uatc_pkg::ST_MISSING;
               else                upd_op        = uatc_pkg::UPD_REMOVE;
            end
            default: ; // unknown codes: no change, all fields zero
         endcase
      end
   end

   // table changes only when the item moves into the result register
   assign upd.valid = s1_advance;
   assign upd.op    = upd_op;

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_access_ff <= rsp_access_in;
         rsp_needs_ff  <= rsp_needs_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.access         = rsp_access_ff;
   assign rsp_ch.needs_passcode = rsp_needs_ff;
   assign rsp_ch.status         = rsp_status_ff;

   // -------------------------------------------------------- assertions
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("item left the input register but no result is held");

   a_disabled_done: assert property (@(posedge clock) disable iff (reset)
      s1_advance && !acl_enabled_ff |=> rsp_status_ff == uatc_pkg::ST_DONE)
      else $error("status other than done with the table disabled");

   a_locked_denies: assert property (@(posedge clock) disable iff (reset)
      s1_advance && acl_enabled_ff && locked_ff &&
      s1_func_ff == uatc_pkg::FUNC_CHECK |=> rsp_access_ff == uatc_pkg::ACC_DENIED)
      else $error("check passed while locked");

   a_no_upd_unless_moving: assert property (@(posedge clock) disable iff (reset)
      upd.valid |-> s1_valid_ff)
      else $error("table command without a held item");

endmodule
